### src/byte_run_length_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// byte_run_length_decoder_core_macros.svh
// Assertion helpers used by the decoder core RTL.
// ----------------------------------------------------------------------------
`ifndef BYTE_RUN_LENGTH_DECODER_CORE_MACROS_SVH
`define BYTE_RUN_LENGTH_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define BRLD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("decoder assertion failed");

// next-cycle implication, disabled during reset
`define BRLD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("decoder assertion failed");

`endif

### src/brld_pkg.sv
// ----------------------------------------------------------------------------
// brld_pkg
// Widths and the result type of the byte run-length decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package brld_pkg;

   localparam int COUNT_WIDTH = 15;
   localparam int TOTAL_WIDTH = 16;
   localparam int BYTE_WIDTH  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TOTAL_WIDTH-1:0] TOTAL_RESET = TOTAL_WIDTH'(1);

   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  value;
      logic [COUNT_WIDTH-1:0] repeat_res;
      logic                   from_run;
      logic                   last;
   } result_type;

endpackage

`default_nettype wire

### src/brld_chan_if.sv
// ----------------------------------------------------------------------------
// brld_chan_if
// Valid/ready channels for coded bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface brld_req_if;
   import brld_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] coded_byte;

   modport source (output valid, output coded_byte, input ready);
   modport sink   (input valid, input coded_byte, output ready);
endinterface

interface brld_rsp_if;
   import brld_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [BYTE_WIDTH-1:0]  value;
   logic [COUNT_WIDTH-1:0] repeat_res;
   logic                   from_run;
   logic                   last;

   modport source (output valid, output value, output repeat_res, output from_run,
                   output last, input ready);
   modport sink   (input valid, input value, input repeat_res, input from_run,
                   input last, output ready);
endinterface

`default_nettype wire

### src/byte_run_length_decoder_core.sv
// ----------------------------------------------------------------------------
// byte_run_length_decoder_core
// Byte run-length decoder: header parser, two-entry queue, output register.
// Throughput: one coded byte per cycle while the queue is not full.
// Result path: queue entry, then output register; either can stall.
// Reset (synchronous): parser back to header low byte, counts cleared,
// element_total set to 1, queue and output register emptied.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_run_length_decoder_core_macros.svh"

module byte_run_length_decoder_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [brld_pkg::TOTAL_WIDTH-1:0] csr_wr_data,
   brld_req_if.sink                              req_if,
   brld_rsp_if.source                            rsp_if
);
   import brld_pkg::*;

   logic       fe_push;
   result_type fe_data;
   logic       q_pop;
   result_type q_data;
   logic       q_full;
   logic       q_empty;

   brld_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_if),
      .q_full      (q_full),
      .push        (fe_push),
      .push_data   (fe_data)
   );

   brld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   brld_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .pop     (q_pop),
      .rsp_if  (rsp_if)
   );

   `BRLD_ASSERT_IMP(a_push_room, clock, reset, fe_push, !q_full)
   `BRLD_ASSERT_IMP(a_pop_data, clock, reset, q_pop, !q_empty)
   `BRLD_ASSERT_IMP(a_rep_nonzero, clock, reset, rsp_if.valid, rsp_if.repeat_res != '0)
   `BRLD_ASSERT_NXT(a_pop_fills, clock, reset, q_pop, rsp_if.valid)

endmodule

`default_nettype wire

### src/brld_front.sv
// ----------------------------------------------------------------------------
// brld_front
// Header parser and element accounting: turns coded bytes into result items.
// ----------------------------------------------------------------------------
`default_nettype none

module brld_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [brld_pkg::TOTAL_WIDTH-1:0] csr_wr_data,
   brld_req_if.sink                          req_if,
   input  wire logic                         q_full,
   output logic                              push,
   output brld_pkg::result_type              push_data
);
   import brld_pkg::*;

   localparam logic [1:0] PH_HDR_LO  = 2'd0;
   localparam logic [1:0] PH_HDR_HI  = 2'd1;
   localparam logic [1:0] PH_VALUE   = 2'd2;
   localparam logic [1:0] PH_LITERAL = 2'd3;

   logic [1:0]             phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_left_ff, count_left_in;
   logic [BYTE_WIDTH-1:0]  header_low_ff, header_low_in;
   logic [TOTAL_WIDTH-1:0] decoded_ff, decoded_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;

   logic                   accept;
   logic                   emit;
   logic [COUNT_WIDTH-1:0] rep;
   logic [COUNT_WIDTH-1:0] hdr_count;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic [TOTAL_WIDTH-1:0] room;
   logic [TOTAL_WIDTH-1:0] rep_ext;
   logic [TOTAL_WIDTH-1:0] n;
   logic                   fin;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign hdr_count    = COUNT_WIDTH'({req_if.coded_byte, header_low_ff});
   assign count_dec    = count_left_ff - COUNT_WIDTH'(1);

   // clamp the item against the elements still expected
   assign rep_ext = TOTAL_WIDTH'(rep);
   assign room    = (total_ff > decoded_ff) ? (total_ff - decoded_ff) : TOTAL_WIDTH'(1);
   assign n       = (rep_ext < room) ? rep_ext : room;
   assign fin     = (n == room);

   always_comb begin
      phase_in      = phase_ff;
      count_left_in = count_left_ff;
      header_low_in = header_low_ff;
      decoded_in    = decoded_ff;
      emit          = 1'b0;
      rep           = COUNT_WIDTH'(1);
      case (phase_ff)
         PH_HDR_LO: begin
            header_low_in = req_if.coded_byte;
            phase_in      = PH_HDR_HI;
         end
         PH_HDR_HI: begin
            count_left_in = hdr_count;
            if (req_if.coded_byte[BYTE_WIDTH-1]) begin
               phase_in = PH_VALUE;
            end else begin
               phase_in = (hdr_count != '0) ? PH_LITERAL : PH_HDR_LO;
            end
         end
         PH_VALUE: begin
            phase_in      = PH_HDR_LO;
            count_left_in = '0;
            rep           = count_left_ff;
            emit          = (count_left_ff != '0);
         end
         default: begin
            count_left_in = count_dec;
            if (count_dec == '0) begin
               phase_in = PH_HDR_LO;
            end
            emit = 1'b1;
         end
      endcase
      if (emit) begin
         if (fin) begin
            // end of block: start over from the header
            phase_in      = PH_HDR_LO;
            count_left_in = '0;
            header_low_in = '0;
            decoded_in    = '0;
         end else begin
            decoded_in = decoded_ff + n;
         end
      end
   end

   assign push                 = accept && emit;
   assign push_data.value      = req_if.coded_byte;
   assign push_data.repeat_res = n[COUNT_WIDTH-1:0];
   assign push_data.from_run   = (phase_ff == PH_VALUE);
   assign push_data.last       = fin;

   assign total_in = csr_wr_en ? csr_wr_data : total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR_LO;
         count_left_ff <= '0;
         header_low_ff <= '0;
         decoded_ff    <= '0;
         total_ff      <= TOTAL_RESET;
      end else begin
         total_ff <= total_in;
         if (accept) begin
            phase_ff      <= phase_in;
            count_left_ff <= count_left_in;
            header_low_ff <= header_low_in;
            decoded_ff    <= decoded_in;
         end
      end
   end

endmodule

`default_nettype wire

### src/brld_queue.sv
// ----------------------------------------------------------------------------
// brld_queue
// Two-entry queue of result items between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module brld_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire brld_pkg::result_type push_data,
   input  wire logic                 pop,
   output brld_pkg::result_type      pop_data,
   output logic                      full,
   output logic                      empty
);
   import brld_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(QUEUE_DEPTH - 1);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### src/brld_back.sv
// ----------------------------------------------------------------------------
// brld_back
// Output stage: moves queued result items onto the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module brld_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire brld_pkg::result_type q_data,
   output logic                      pop,
   brld_rsp_if.source                rsp_if
);
   import brld_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // advance when the output register is free or being taken
   assign pop      = !q_empty && (!valid_ff || rsp_if.ready);
   assign valid_in = pop || (valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= q_data;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.value      = data_ff.value;
   assign rsp_if.repeat_res = data_ff.repeat_res;
   assign rsp_if.from_run   = data_ff.from_run;
   assign rsp_if.last       = data_ff.last;

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the byte run-length decoder. Coded byte streams (runs,
// literals, zero counts, clamped runs and cut-off literals, plus raw noise)
// are fed in under several element totals and idling mixes. A behavioral
// decoder tracks the header state and queues the element items it expects;
// every result item is checked field by field against the oldest one.
// ----------------------------------------------------------------------------

module tb_top;
   import brld_pkg::*;

   localparam int                   CYCLE_LIMIT   = 200000;
   localparam int                   SETTLE_CYCLES = 8;
   localparam logic [15:0]          REPEAT_FLAG   = 16'h8000;
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX   = '1;

   typedef enum logic [1:0] {
      ST_HEADER_LO,
      ST_HEADER_HI,
      ST_RUN_VALUE,
      ST_LITERAL
   } decode_phase_e;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_wr_en;
   logic [TOTAL_WIDTH-1:0] csr_wr_data;

   brld_req_if req_ch ();
   brld_rsp_if rsp_ch ();

   byte_run_length_decoder_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_if     (req_ch),
      .rsp_if     (rsp_ch)
   );

   always #6 clock = ~clock;

   // decoder state as the block should hold it
   logic [TOTAL_WIDTH-1:0] total_cfg;
   decode_phase_e          m_phase;
   logic [COUNT_WIDTH-1:0] m_count_left;
   logic [BYTE_WIDTH-1:0]  m_header_low;
   logic [TOTAL_WIDTH-1:0] m_decoded;
   result_type             decoded_q[$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int bytes_sent    = 0;
   int src_idle_pct  = 0;
   int snk_idle_pct  = 0;
   int rx_hold_len   = 0;
   int rx_hold_seq   = 0;

   function automatic void clear_block();
      m_phase      = ST_HEADER_LO;
      m_count_left = '0;
      m_header_low = '0;
      m_decoded    = '0;
   endfunction

   function automatic void push_element(input logic [BYTE_WIDTH-1:0] val,
                                        input logic [COUNT_WIDTH-1:0] rep,
                                        input logic run);
      logic [TOTAL_WIDTH:0] room;
      logic [TOTAL_WIDTH:0] n;
      result_type           r;
      // room never drops below one, even when the total is already reached
      room = (total_cfg > m_decoded) ? ({1'b0, total_cfg} - {1'b0, m_decoded})
                                     : (TOTAL_WIDTH+1)'(1);
      n = ((TOTAL_WIDTH+1)'(rep) < room) ? (TOTAL_WIDTH+1)'(rep) : room;
      r.value      = val;
      r.repeat_res = n[COUNT_WIDTH-1:0];
      r.from_run   = run;
      r.last       = (n == room);
      decoded_q.push_back(r);
      if (r.last) begin
         clear_block();
      end else begin
         m_decoded = m_decoded + n[TOTAL_WIDTH-1:0];
      end
   endfunction

   function automatic void decode_byte(input logic [BYTE_WIDTH-1:0] b);
      logic [15:0]            hdr;
      logic [COUNT_WIDTH-1:0] cnt;
      case (m_phase)
         ST_HEADER_LO: begin
            m_header_low = b;
            m_phase      = ST_HEADER_HI;
         end
         ST_HEADER_HI: begin
            hdr          = {b, m_header_low};
            cnt          = hdr[COUNT_WIDTH-1:0];
            m_count_left = cnt;
            if ((hdr & REPEAT_FLAG) != 16'h0) begin
               m_phase = ST_RUN_VALUE;
            end else begin
               m_phase = (cnt != '0) ? ST_LITERAL : ST_HEADER_LO;
            end
         end
         ST_RUN_VALUE: begin
            cnt          = m_count_left;
            m_phase      = ST_HEADER_LO;
            m_count_left = '0;
            if (cnt != '0) push_element(b, cnt, 1'b1);
         end
         default: begin
            m_count_left = m_count_left - 1'b1;
            if (m_count_left == '0) m_phase = ST_HEADER_LO;
            push_element(b, COUNT_WIDTH'(1), 1'b0);
         end
      endcase
   endfunction

   // offer one coded byte, hold it until taken; valid stays high on return
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] b);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.coded_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      decode_byte(b);
      bytes_sent = bytes_sent + 1;
      @(negedge clock);
   endtask

   task automatic send_header(input logic run, input logic [COUNT_WIDTH-1:0] cnt);
      logic [15:0] hdr;
      hdr = run ? (REPEAT_FLAG | 16'(cnt)) : 16'(cnt);
      send_byte(hdr[7:0]);
      send_byte(hdr[15:8]);
   endtask

   task automatic send_run(input logic [COUNT_WIDTH-1:0] cnt, input logic [BYTE_WIDTH-1:0] val);
      send_header(1'b1, cnt);
      send_byte(val);
   endtask

   // stop early when the block drops the rest of a literal at the total
   task automatic send_literal(input logic [COUNT_WIDTH-1:0] cnt);
      send_header(1'b0, cnt);
      while (m_phase == ST_LITERAL) send_byte(BYTE_WIDTH'($urandom_range(0, 255)));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_total(input logic [TOTAL_WIDTH-1:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      total_cfg = v;
   endtask

   task automatic test_directed();
      src_idle_pct = 23;
      snk_idle_pct = 56;
      // total still at its reset value of one: the run is clamped to one element
      send_run(COUNT_WIDTH'(5), 8'h3C);
      write_total(TOTAL_MAX);
      send_run('1, 8'hFF);
      send_run('0, 8'h81);
      send_header(1'b0, '0);
      send_header(1'b0, COUNT_WIDTH'(2));
      send_byte(8'h00);
      send_byte(8'hFF);
      // overruns the remaining room of the block
      send_run('1, 8'h00);
      write_total(TOTAL_WIDTH'(3));
      // third byte completes the total, rest of the literal is dropped
      send_header(1'b0, COUNT_WIDTH'(6));
      send_byte(8'h11);
      send_byte(8'h22);
      send_byte(8'h33);
      send_run(COUNT_WIDTH'(2), 8'h44);
      // total now below what the block has already decoded
      write_total(TOTAL_WIDTH'(1));
      send_run(COUNT_WIDTH'(3), 8'h55);
   endtask

   task automatic test_backpressure();
      src_idle_pct = 0;
      snk_idle_pct = 0;
      write_total(TOTAL_WIDTH'(200));
      @(posedge clock);
      rx_hold_len = 300;
      rx_hold_seq = rx_hold_seq + 1;
      @(negedge clock);
      repeat (40) begin
         send_run(COUNT_WIDTH'($urandom_range(1, 3)), BYTE_WIDTH'($urandom_range(0, 255)));
      end
      drain_results();
   endtask

   task automatic test_random_traffic(input int n_bytes, input int src_pct, input int snk_pct,
                                      input logic [TOTAL_WIDTH-1:0] total, input bit with_noise);
      int                     first;
      int                     pick;
      logic [COUNT_WIDTH-1:0] cnt;
      write_total(total);
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      first = bytes_sent;
      while (bytes_sent - first < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (with_noise && pick < 20) begin
            repeat ($urandom_range(1, 3)) send_byte(BYTE_WIDTH'($urandom_range(0, 255)));
            // resync on a header boundary; short totals keep this bounded
            while (m_phase != ST_HEADER_LO) send_byte(BYTE_WIDTH'($urandom_range(0, 255)));
         end else if (pick < 60) begin
            if ($urandom_range(0, 3) == 0) begin
               cnt = COUNT_WIDTH'($urandom_range(0, 32767));
            end else begin
               cnt = COUNT_WIDTH'($urandom_range(0, 6));
            end
            send_run(cnt, BYTE_WIDTH'($urandom_range(0, 255)));
         end else begin
            send_literal(COUNT_WIDTH'($urandom_range(0, 12)));
         end
      end
   endtask

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      int hold_left;
      int hold_taken;
      hold_left    = 0;
      hold_taken   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_seq != hold_taken) begin
            hold_taken = rx_hold_seq;
            hold_left  = rx_hold_len;
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (decoded_q.size() == 0) begin
            $error("result item with nothing expected: value %0d repeat_res %0d",
                   rsp_ch.value, rsp_ch.repeat_res);
            fail_count = fail_count + 1;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_ch.value !== want.value) begin
               $error("value: expected %0d, actual %0d", want.value, rsp_ch.value);
               fail_count = fail_count + 1;
            end
            if (rsp_ch.repeat_res !== want.repeat_res) begin
               $error("repeat_res: expected %0d, actual %0d", want.repeat_res, rsp_ch.repeat_res);
               fail_count = fail_count + 1;
            end
            if (rsp_ch.from_run !== want.from_run) begin
               $error("from_run: expected %0d, actual %0d", want.from_run, rsp_ch.from_run);
               fail_count = fail_count + 1;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("byte_run_length_decoder_core regression: fail");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_ch.valid      = 1'b0;
      req_ch.coded_byte = '0;
      total_cfg         = TOTAL_RESET;
      clear_block();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_traffic(350, 23, 56, TOTAL_WIDTH'($urandom_range(1, 40)), 1'b1);
      test_random_traffic(350, 56, 23, TOTAL_WIDTH'($urandom_range(100, 256)), 1'b1);
      test_backpressure();
      test_random_traffic(300, 0, 0, TOTAL_MAX, 1'b0);
      drain_results();

      if (fail_count == 0) begin
         $display("byte_run_length_decoder_core regression: pass");
      end else begin
         $display("byte_run_length_decoder_core regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/brld_pkg.sv
src/brld_chan_if.sv
src/brld_front.sv
src/brld_queue.sv
src/brld_back.sv
src/byte_run_length_decoder_core.sv
verif/tb_top.sv
